// ===== rtl/cra_pkg.sv =====
package cra_pkg;

  // Configuration port geometry: four 64-bit registers at 8-byte strides
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgAddrW  = 5;
  localparam int unsigned CfgIdxLsb = 3;
  localparam int unsigned CfgIdxW   = 2;

  localparam int unsigned XlenW = 64;
  localparam int unsigned CrNumW = 4;
  localparam int unsigned GprW = 4;
  localparam int unsigned LmswW = 16;

  // Control register numbers that are emulated
  localparam logic [CrNumW-1:0] CrNum0 = 4'd0;
  localparam logic [CrNumW-1:0] CrNum3 = 4'd3;
  localparam logic [CrNumW-1:0] CrNum4 = 4'd4;

  // Architectural bit masks
  localparam logic [XlenW-1:0] MaskTs      = 64'h0000_0000_0000_0008;
  localparam logic [XlenW-1:0] MaskVmxe    = 64'h0000_0000_0000_2000;
  localparam logic [XlenW-1:0] MaskPe      = 64'h0000_0000_0000_0001;
  localparam logic [XlenW-1:0] MaskLowNib  = 64'h0000_0000_0000_000f;

  typedef enum logic [1:0] {
    ACC_MOV_TO   = 2'd0,
    ACC_MOV_FROM = 2'd1,
    ACC_CLTS     = 2'd2,
    ACC_LMSW     = 2'd3
  } acc_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CR0_FIXED   = 2'd0,
    REG_CR0_ALLOWED = 2'd1,
    REG_CR4_FIXED   = 2'd2,
    REG_CR4_ALLOWED = 2'd3
  } cfg_reg_e;

  // Mask settings handed from the register file to the datapath
  typedef struct packed {
    logic [XlenW-1:0] cr0_fixed;
    logic [XlenW-1:0] cr0_allowed;
    logic [XlenW-1:0] cr4_fixed;
    logic [XlenW-1:0] cr4_allowed;
  } cra_cfg_t;

  // Effective value from requested value and fixed/allowed masks
  function automatic logic [XlenW-1:0] eff_value(input logic [XlenW-1:0] req,
                                                 input logic [XlenW-1:0] fixed,
                                                 input logic [XlenW-1:0] allowed);
    return (req | fixed) & allowed;
  endfunction

endpackage

// ===== rtl/cra_ifs.sv =====
interface cra_req_if
  import cra_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CrNumW-1:0] cr_number;
  logic [1:0]        access_type;
  logic [GprW-1:0]   gpr_index;
  logic [LmswW-1:0]  lmsw_source;
  logic [XlenW-1:0]  source_value;

  modport source (output valid, cr_number, access_type, gpr_index, lmsw_source,
                  source_value, input ready);
  modport sink   (input valid, cr_number, access_type, gpr_index, lmsw_source,
                  source_value, output ready);
endinterface

interface cra_rsp_if
  import cra_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             handled;
  logic             gpr_write;
  logic [GprW-1:0]  dest_gpr;
  logic [XlenW-1:0] gpr_value;
  logic [XlenW-1:0] effective_cr0;
  logic [XlenW-1:0] shadow_cr0;
  logic [XlenW-1:0] current_cr3;
  logic [XlenW-1:0] effective_cr4;
  logic [XlenW-1:0] shadow_cr4;

  modport source (output valid, handled, gpr_write, dest_gpr, gpr_value, effective_cr0,
                  shadow_cr0, current_cr3, effective_cr4, shadow_cr4, input ready);
  modport sink   (input valid, handled, gpr_write, dest_gpr, gpr_value, effective_cr0,
                  shadow_cr0, current_cr3, effective_cr4, shadow_cr4, output ready);
endinterface

// ===== rtl/cra_cfg_regs.sv =====
module cra_cfg_regs
  import cra_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cra_cfg_t            cfg_o
);

  cra_cfg_t cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_e'(paddr[CfgIdxLsb +: CfgIdxW]);

  // Decode the write request
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_CR0_FIXED:   cfg_d.cr0_fixed   = pwdata;
        REG_CR0_ALLOWED: cfg_d.cr0_allowed = pwdata;
        REG_CR4_FIXED:   cfg_d.cr4_fixed   = pwdata;
        REG_CR4_ALLOWED: cfg_d.cr4_allowed = pwdata;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (reg_sel)
      REG_CR0_FIXED:   prdata = cfg_q.cr0_fixed;
      REG_CR0_ALLOWED: prdata = cfg_q.cr0_allowed;
      REG_CR4_FIXED:   prdata = cfg_q.cr4_fixed;
      REG_CR4_ALLOWED: prdata = cfg_q.cr4_allowed;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cr0_fixed   <= '0;
      cfg_q.cr0_allowed <= '1;
      cfg_q.cr4_fixed   <= '0;
      cfg_q.cr4_allowed <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/cra_exec.sv =====
module cra_exec
  import cra_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cra_cfg_t cfg_i,
  cra_req_if.sink   req_i,
  cra_rsp_if.source rsp_o
);

  // Input register
  logic              s1_valid_q, s1_valid_d;
  logic [CrNumW-1:0] s1_cr_q;
  acc_e              s1_acc_q;
  logic [GprW-1:0]   s1_gpr_q;
  logic [3:0]        s1_lmsw_q;
  logic [XlenW-1:0]  s1_src_q;

  // Architectural state
  logic [XlenW-1:0] cr0_shadow_q, cr0_shadow_d;
  logic [XlenW-1:0] cr0_eff_q, cr0_eff_d;
  logic [XlenW-1:0] cr3_q, cr3_d;
  logic [XlenW-1:0] cr4_shadow_q, cr4_shadow_d;
  logic [XlenW-1:0] cr4_eff_q, cr4_eff_d;

  // Result register
  logic             rsp_valid_q, rsp_valid_d;
  logic             handled_q, handled_d;
  logic             gpr_wr_q, gpr_wr_d;
  logic [GprW-1:0]  dest_q, dest_d;
  logic [XlenW-1:0] value_q, value_d;

  logic             req_acc;
  logic             s1_adv;
  logic             cr0_wr;
  logic [XlenW-1:0] cr0_req;
  logic             is_cr0, is_cr3, is_cr4;

  // Handshake: the input stage moves on whenever the result slot is free
  assign s1_adv      = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_acc     = req_i.valid && req_i.ready;
  assign s1_valid_d  = req_acc || (s1_valid_q && !s1_adv);
  assign rsp_valid_d = s1_adv || (rsp_valid_q && !rsp_o.ready);

  assign is_cr0 = (s1_cr_q == CrNum0);
  assign is_cr3 = (s1_cr_q == CrNum3);
  assign is_cr4 = (s1_cr_q == CrNum4);

  // Emulate the access held in the input register
  always_comb begin
    cr0_wr       = 1'b0;
    cr0_req      = s1_src_q;
    cr3_d        = cr3_q;
    cr4_shadow_d = cr4_shadow_q;
    cr4_eff_d    = cr4_eff_q;
    handled_d    = 1'b0;
    gpr_wr_d     = 1'b0;
    dest_d       = '0;
    value_d      = '0;
    case (s1_acc_q)
      ACC_MOV_TO: begin
        if (is_cr0) begin
          cr0_wr    = 1'b1;
          handled_d = 1'b1;
        end else if (is_cr3) begin
          cr3_d     = s1_src_q;
          handled_d = 1'b1;
        end else if (is_cr4) begin
          cr4_shadow_d = s1_src_q;
          cr4_eff_d    = eff_value(s1_src_q, cfg_i.cr4_fixed | MaskVmxe, cfg_i.cr4_allowed);
          handled_d    = 1'b1;
        end
      end
      ACC_MOV_FROM: begin
        if (is_cr0 || is_cr3 || is_cr4) begin
          handled_d = 1'b1;
          gpr_wr_d  = 1'b1;
          dest_d    = s1_gpr_q;
          value_d   = is_cr0 ? cr0_shadow_q : (is_cr3 ? cr3_q : cr4_shadow_q);
        end
      end
      ACC_CLTS: begin
        if (is_cr0) begin
          cr0_wr    = 1'b1;
          cr0_req   = cr0_shadow_q & ~MaskTs;
          handled_d = 1'b1;
        end
      end
      default: begin
        // LMSW sets the low nibble but never clears PE
        if (is_cr0) begin
          cr0_wr    = 1'b1;
          cr0_req   = (cr0_shadow_q & ~MaskLowNib)
                    | ({{(XlenW-4){1'b0}}, s1_lmsw_q} & MaskLowNib)
                    | (cr0_shadow_q & MaskPe);
          handled_d = 1'b1;
        end
      end
    endcase
    cr0_shadow_d = cr0_wr ? cr0_req : cr0_shadow_q;
    cr0_eff_d    = cr0_wr ? eff_value(cr0_req, cfg_i.cr0_fixed, cfg_i.cr0_allowed)
                          : cr0_eff_q;
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      rsp_valid_q  <= 1'b0;
      cr0_shadow_q <= '0;
      cr0_eff_q    <= '0;
      cr3_q        <= '0;
      cr4_shadow_q <= '0;
      cr4_eff_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
      if (s1_adv) begin
        cr0_shadow_q <= cr0_shadow_d;
        cr0_eff_q    <= cr0_eff_d;
        cr3_q        <= cr3_d;
        cr4_shadow_q <= cr4_shadow_d;
        cr4_eff_q    <= cr4_eff_d;
      end
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_cr_q   <= req_i.cr_number;
      s1_acc_q  <= acc_e'(req_i.access_type);
      s1_gpr_q  <= req_i.gpr_index;
      s1_lmsw_q <= req_i.lmsw_source[3:0];
      s1_src_q  <= req_i.source_value;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      handled_q <= handled_d;
      gpr_wr_q  <= gpr_wr_d;
      dest_q    <= dest_d;
      value_q   <= value_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.handled       = handled_q;
  assign rsp_o.gpr_write     = gpr_wr_q;
  assign rsp_o.dest_gpr      = dest_q;
  assign rsp_o.gpr_value     = value_q;
  assign rsp_o.effective_cr0 = cr0_eff_q;
  assign rsp_o.shadow_cr0    = cr0_shadow_q;
  assign rsp_o.current_cr3   = cr3_q;
  assign rsp_o.effective_cr4 = cr4_eff_q;
  assign rsp_o.shadow_cr4    = cr4_shadow_q;

`ifndef ASSERT_OFF
  a_load_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> s1_valid_q)
    else $error("accepted request did not reach the input stage");

  a_free_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> req_i.ready)
    else $error("input stage empty but request not taken");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(cr3_q) && $stable(cr0_shadow_q) && $stable(cr4_shadow_q)
                && $stable(cr0_eff_q) && $stable(cr4_eff_q))
    else $error("state changed without an executed request");

  a_unhandled_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !handled_q) |-> (!gpr_wr_q && dest_q == '0 && value_q == '0))
    else $error("unhandled access carries write-back data");
`endif

endmodule

// ===== rtl/control_register_access_emulator_core.sv =====
// Flow: a request accepted into the input register is executed from it, and its result is
// loaded into the result register when the input stage advances; a ready sink takes it from there.
// Throughput: one request per cycle while the sink takes each result; the input register and
// the result register each take a new entry in the cycle the next stage frees them.
// Reset: asynchronous, active low; clears the emulated CR state to zero, the
// fixed-ones masks to zero and the allowed-ones masks to all ones.
module control_register_access_emulator_core
  import cra_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  cra_req_if.sink             req_i,
  cra_rsp_if.source           rsp_o
);

  cra_cfg_t cfg;

  // Mask register file
  cra_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Access pipeline
  cra_exec u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
